@@ rtl/fpfa_pkg.sv @@
// Package for the fixed-partition fit allocator.
// Holds the request and response payload types, the codes and the search control struct.
// Has no dependencies; every other file of the block imports it.
package fpfa_pkg;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   localparam logic [1:0] POLICY_FIRST = 2'd0;
   localparam logic [1:0] POLICY_BEST  = 2'd1;
   localparam logic [1:0] POLICY_WORST = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_NO_FIT  = 2'd2;

   typedef struct packed {
      logic        opcode;
      logic [15:0] amount;
      logic [7:0]  owner_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  block_index;
      logic [15:0] slot_size;
      logic [3:0]  free_slots;
      logic [18:0] free_total;
      logic [3:0]  taken_slots;
      logic [18:0] occupied_total;
   } rsp_type;

   typedef struct packed {
      logic       active;
      logic       found;
      logic [1:0] policy;
   } search_ctl_type;

   typedef struct packed {
      logic add;
      logic take;
   } cell_cmd_type;

endpackage

@@ rtl/fpfa_cell.sv @@
// One partition cell of the allocator chain: holds one table entry and one search stage.
// Depends on fpfa_pkg for the search control and command structs.
// The search record moves from each cell to the next one every cycle.
module fpfa_cell import fpfa_pkg::*; #(
   parameter int SIZE_BITS = 16,
   parameter int IDX_W     = 3,
   parameter int CELL_IDX  = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  search_ctl_type       ctl_in,
   input  logic [SIZE_BITS-1:0] need_in,
   input  logic [IDX_W-1:0]     pick_idx_in,
   input  logic [SIZE_BITS-1:0] pick_size_in,
   output search_ctl_type       ctl_out,
   output logic [SIZE_BITS-1:0] need_out,
   output logic [IDX_W-1:0]     pick_idx_out,
   output logic [SIZE_BITS-1:0] pick_size_out,
   input  cell_cmd_type         cmd,
   input  logic [IDX_W-1:0]     cmd_idx,
   input  logic [SIZE_BITS-1:0] cmd_size,
   input  logic [7:0]           cmd_owner
);

   logic                 in_use_ff, in_use_in;
   logic                 free_ff, free_in;
   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [7:0]           owner_ff, owner_in;
   search_ctl_type       ctl_ff, ctl_in_next;
   logic [SIZE_BITS-1:0] need_ff, need_in_next;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SIZE_BITS-1:0] pick_ff, pick_in;
   logic                 hit;
   logic                 take;
   logic                 selected;

   always_comb begin
      hit  = ctl_in.active && in_use_ff && free_ff && (size_ff >= need_in);
      take = hit && (!ctl_in.found ||
                     (ctl_in.policy == POLICY_BEST  && size_ff < pick_size_in) ||
                     (ctl_in.policy == POLICY_WORST && size_ff > pick_size_in));

      ctl_in_next        = ctl_in;
      ctl_in_next.found  = ctl_in.found || hit;
      need_in_next       = need_in;
      idx_in             = take ? IDX_W'(CELL_IDX) : pick_idx_in;
      pick_in            = take ? size_ff : pick_size_in;

      selected  = (cmd_idx == IDX_W'(CELL_IDX));
      in_use_in = in_use_ff;
      free_in   = free_ff;
      size_in   = size_ff;
      owner_in  = owner_ff;
      if (cmd.add && selected) begin
         in_use_in = 1'b1;
         free_in   = 1'b1;
         size_in   = cmd_size;
         owner_in  = '0;
      end else if (cmd.take && selected) begin
         free_in  = 1'b0;
         owner_in = cmd_owner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= 1'b0;
         free_ff   <= 1'b1;
         ctl_ff    <= '0;
      end else begin
         in_use_ff <= in_use_in;
         free_ff   <= free_in;
         ctl_ff    <= ctl_in_next;
      end
      size_ff  <= size_in;
      owner_ff <= owner_in;
      need_ff  <= need_in_next;
      idx_ff   <= idx_in;
      pick_ff  <= pick_in;
   end

   assign ctl_out       = ctl_ff;
   assign need_out      = need_ff;
   assign pick_idx_out  = idx_ff;
   assign pick_size_out = pick_ff;

endmodule

@@ rtl/fixed_partition_fit_allocator_core.sv @@
// Top level of the fixed-partition fit allocator: control sequencer, totals and cell chain.
// Depends on fpfa_pkg and instantiates fpfa_cell once per partition.
// An allocate request passes ST_LAUNCH and ST_SEARCH, as the search record walks the chain
// of MAX_PARTS cells one cell per cycle; an add goes straight to ST_REPLY, which waits for
// a free output register. One request is in flight at a time; a new one is accepted while
// the last response waits in the output register. The user must write the search policy
// through the csr port while no request is in flight (not enforced); code 3 is first fit.
module fixed_partition_fit_allocator_core import fpfa_pkg::*; #(
   parameter int MAX_PARTS = 8,
   parameter int SIZE_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data
);

   localparam int IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
   localparam int CNT_W = $clog2(MAX_PARTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SEARCH,
      ST_REPLY
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           policy_ff, policy_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [3:0]           fb_ff, fb_in;
   logic [18:0]          ft_ff, ft_in;
   logic [3:0]           ob_ff, ob_in;
   logic [18:0]          ot_ff, ot_in;
   req_type              req_ff, req_in;
   rsp_type              pend_ff, pend_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   search_ctl_type       ctl_w  [MAX_PARTS+1];
   logic [SIZE_BITS-1:0] need_w [MAX_PARTS+1];
   logic [IDX_W-1:0]     idx_w  [MAX_PARTS+1];
   logic [SIZE_BITS-1:0] pick_w [MAX_PARTS+1];

   cell_cmd_type         cmd;
   logic [IDX_W-1:0]     cmd_idx;
   logic [SIZE_BITS-1:0] cmd_size;
   logic [SIZE_BITS-1:0] amount_sized;
   logic                 req_accept;
   logic                 table_full;
   logic                 rsp_free;

   assign amount_sized = SIZE_BITS'(req_data.amount);
   assign req_accept   = req_valid && req_ready;
   assign table_full   = (count_ff == CNT_W'(MAX_PARTS));
   assign rsp_free     = !rsp_valid_ff || rsp_ready;

   assign ctl_w[0].active = (state_ff == ST_LAUNCH);
   assign ctl_w[0].found  = 1'b0;
   assign ctl_w[0].policy = policy_ff;
   assign need_w[0]       = SIZE_BITS'(req_ff.amount);
   assign idx_w[0]        = '0;
   assign pick_w[0]       = '0;

   for (genvar i = 0; i < MAX_PARTS; i++) begin : g_cell
      fpfa_cell #(
         .SIZE_BITS (SIZE_BITS),
         .IDX_W     (IDX_W),
         .CELL_IDX  (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl_in        (ctl_w[i]),
         .need_in       (need_w[i]),
         .pick_idx_in   (idx_w[i]),
         .pick_size_in  (pick_w[i]),
         .ctl_out       (ctl_w[i+1]),
         .need_out      (need_w[i+1]),
         .pick_idx_out  (idx_w[i+1]),
         .pick_size_out (pick_w[i+1]),
         .cmd           (cmd),
         .cmd_idx       (cmd_idx),
         .cmd_size      (cmd_size),
         .cmd_owner     (req_ff.owner_id)
      );
   end

   always_comb begin
      state_in     = state_ff;
      policy_in    = (csr_valid && csr_ready) ? csr_data : policy_ff;
      count_in     = count_ff;
      fb_in        = fb_ff;
      ft_in        = ft_ff;
      ob_in        = ob_ff;
      ot_in        = ot_ff;
      req_in       = req_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd_idx      = IDX_W'(count_ff);
      cmd_size     = amount_sized;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_in  = req_data;
               pend_in = '0;
               if (req_data.opcode == OP_ALLOC) begin
                  state_in = ST_LAUNCH;
               end else begin
                  state_in = ST_REPLY;
                  if (table_full) begin
                     pend_in.status = STATUS_FULL;
                  end else begin
                     cmd.add             = 1'b1;
                     count_in            = count_ff + CNT_W'(1);
                     fb_in               = fb_ff + 4'd1;
                     ft_in               = ft_ff + 19'(amount_sized);
                     pend_in.status      = STATUS_OK;
                     pend_in.block_index = 3'(count_ff);
                     pend_in.slot_size   = 16'(amount_sized);
                  end
                  pend_in.free_slots     = pend_in.status == STATUS_OK ? fb_in : fb_ff;
                  pend_in.free_total     = pend_in.status == STATUS_OK ? ft_in : ft_ff;
                  pend_in.taken_slots    = ob_ff;
                  pend_in.occupied_total = ot_ff;
               end
            end
         end
         ST_LAUNCH: begin
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (ctl_w[MAX_PARTS].active) begin
               state_in = ST_REPLY;
               pend_in  = '0;
               if (ctl_w[MAX_PARTS].found) begin
                  cmd.take            = 1'b1;
                  cmd_idx             = idx_w[MAX_PARTS];
                  fb_in               = fb_ff - 4'd1;
                  ft_in               = ft_ff - 19'(pick_w[MAX_PARTS]);
                  ob_in               = ob_ff + 4'd1;
                  ot_in               = ot_ff + 19'(pick_w[MAX_PARTS]);
                  pend_in.status      = STATUS_OK;
                  pend_in.block_index = 3'(idx_w[MAX_PARTS]);
                  pend_in.slot_size   = 16'(pick_w[MAX_PARTS]);
               end else begin
                  pend_in.status = STATUS_NO_FIT;
               end
               pend_in.free_slots     = fb_in;
               pend_in.free_total     = ft_in;
               pend_in.taken_slots    = ob_in;
               pend_in.occupied_total = ot_in;
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         policy_ff    <= POLICY_FIRST;
         count_ff     <= '0;
         fb_ff        <= '0;
         ft_ff        <= '0;
         ob_ff        <= '0;
         ot_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         count_ff     <= count_in;
         fb_ff        <= fb_in;
         ft_ff        <= ft_in;
         ob_ff        <= ob_in;
         ot_ff        <= ot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ verif/fixed_partition_fit_allocator_core_test.sv @@
// Self-checking testbench for fixed_partition_fit_allocator_core: adds and allocations
// under every search policy, checked field by field against a table predictor.
// Depends on fpfa_pkg and the RTL of fixed_partition_fit_allocator_core only.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_core_test;
   import fpfa_pkg::*;

   localparam int TABLE_DEPTH = 8;
   localparam int RANDOM_PER_PHASE = 500;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam logic [1:0] POLICY_RESERVED = 2'd3;

   typedef struct {
      logic [1:0] policy;
      req_type    req;
      bit         typed;
      rsp_type    want;
   } plan_entry_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_data = 2'd0;

   logic [15:0] size_of [TABLE_DEPTH];
   logic        is_free [TABLE_DEPTH];
   logic [7:0]  owner_of [TABLE_DEPTH];
   int unsigned used_parts = 0;
   logic [1:0]  policy_now = POLICY_FIRST;

   rsp_type        pending_outcomes [$];
   plan_entry_type directed_plan [$];
   rsp_type        oldest;
   int        mismatches = 0;
   int        request_count = 0;
   int        response_count = 0;
   int        placed_count = 0;
   int        full_count = 0;
   int        no_fit_count = 0;
   int        quiet_cycles = 0;
   int        send_idle_pct = 0;
   int        rsp_stall_pct = 0;

   fixed_partition_fit_allocator_core #(
      .MAX_PARTS(TABLE_DEPTH),
      .SIZE_BITS(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("fixed_partition_fit_allocator_core_test: done, errors");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function automatic rsp_type table_outcome(input req_type r);
      rsp_type     o;
      int          pick;
      int unsigned fb;
      int unsigned ft;
      int unsigned ob;
      int unsigned ot;
      o = '0;
      pick = -1;
      fb = 0;
      ft = 0;
      ob = 0;
      ot = 0;
      if (r.opcode == OP_ADD) begin
         if (used_parts >= TABLE_DEPTH) begin
            o.status = STATUS_FULL;
         end else begin
            size_of[used_parts] = r.amount;
            is_free[used_parts] = 1'b1;
            owner_of[used_parts] = '0;
            o.status = STATUS_OK;
            o.block_index = 3'(used_parts);
            o.slot_size = r.amount;
            used_parts++;
         end
      end else begin
         for (int i = 0; i < used_parts; i++) begin
            if (is_free[i] && size_of[i] >= r.amount) begin
               if (pick < 0) begin
                  pick = i;
               end else if (policy_now == POLICY_BEST && size_of[i] < size_of[pick]) begin
                  pick = i;
               end else if (policy_now == POLICY_WORST && size_of[i] > size_of[pick]) begin
                  pick = i;
               end
            end
         end
         if (pick < 0) begin
            o.status = STATUS_NO_FIT;
         end else begin
            is_free[pick] = 1'b0;
            owner_of[pick] = r.owner_id;
            o.status = STATUS_OK;
            o.block_index = 3'(pick);
            o.slot_size = size_of[pick];
         end
      end
      for (int i = 0; i < used_parts; i++) begin
         if (is_free[i]) begin
            fb++;
            ft += size_of[i];
         end else begin
            ob++;
            ot += size_of[i];
         end
      end
      o.free_slots = 4'(fb);
      o.free_total = 19'(ft);
      o.taken_slots = 4'(ob);
      o.occupied_total = 19'(ot);
      return o;
   endfunction

   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      request_count++;
      if (typed) begin
         void'(table_outcome(r));
         pending_outcomes.push_back(want);
      end else begin
         pending_outcomes.push_back(table_outcome(r));
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_outcomes.size() != 0);
   endtask

   task automatic write_policy(input logic [1:0] p);
      csr_valid <= 1'b1;
      csr_data <= p;
      do @(posedge clock); while (!csr_ready);
      policy_now = p;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic plan_row(input logic [1:0] pol, input logic op, input int amt,
                           input int owner);
      plan_entry_type e;
      e.policy = pol;
      e.req.opcode = op;
      e.req.amount = 16'(amt);
      e.req.owner_id = 8'(owner);
      e.typed = 1'b0;
      e.want = '0;
      directed_plan.push_back(e);
   endtask

   task automatic plan_checked(input logic [1:0] pol, input logic op, input int amt,
                               input int owner, input logic [1:0] st, input int idx,
                               input int blk, input int fb, input int ft, input int ob,
                               input int ot);
      plan_entry_type e;
      e.policy = pol;
      e.req.opcode = op;
      e.req.amount = 16'(amt);
      e.req.owner_id = 8'(owner);
      e.typed = 1'b1;
      e.want.status = st;
      e.want.block_index = 3'(idx);
      e.want.slot_size = 16'(blk);
      e.want.free_slots = 4'(fb);
      e.want.free_total = 19'(ft);
      e.want.taken_slots = 4'(ob);
      e.want.occupied_total = 19'(ot);
      directed_plan.push_back(e);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         response_count++;
         case (rsp_data.status)
            STATUS_OK: placed_count++;
            STATUS_FULL: full_count++;
            default: no_fit_count++;
         endcase
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("response with no request pending, status %0d",
                                      rsp_data.status));
         end else begin
            oldest = pending_outcomes.pop_front();
            if (rsp_data.status !== oldest.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_data.status, oldest.status));
            if (rsp_data.block_index !== oldest.block_index)
               report_mismatch($sformatf("block_index %0d, expected %0d",
                                         rsp_data.block_index, oldest.block_index));
            if (rsp_data.slot_size !== oldest.slot_size)
               report_mismatch($sformatf("slot_size %0d, expected %0d",
                                         rsp_data.slot_size, oldest.slot_size));
            if (rsp_data.free_slots !== oldest.free_slots)
               report_mismatch($sformatf("free_slots %0d, expected %0d",
                                         rsp_data.free_slots, oldest.free_slots));
            if (rsp_data.free_total !== oldest.free_total)
               report_mismatch($sformatf("free_total %0d, expected %0d",
                                         rsp_data.free_total, oldest.free_total));
            if (rsp_data.taken_slots !== oldest.taken_slots)
               report_mismatch($sformatf("taken_slots %0d, expected %0d",
                                         rsp_data.taken_slots, oldest.taken_slots));
            if (rsp_data.occupied_total !== oldest.occupied_total)
               report_mismatch($sformatf("occupied_total %0d, expected %0d",
                                         rsp_data.occupied_total, oldest.occupied_total));
         end
      end
   end

   initial begin
      logic [1:0] phase_policy [3];
      req_type    r;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         size_of[i] = '0;
         is_free[i] = 1'b1;
         owner_of[i] = '0;
      end

      // An empty table refuses any allocation; eight adds fill it, a ninth is refused.
      plan_checked(POLICY_FIRST, OP_ALLOC, 0, 255, STATUS_NO_FIT, 0, 0, 0, 0, 0, 0);
      plan_checked(POLICY_FIRST, OP_ADD, 65535, 0, STATUS_OK, 0, 65535, 1, 65535, 0, 0);
      plan_checked(POLICY_FIRST, OP_ADD, 0, 255, STATUS_OK, 1, 0, 2, 65535, 0, 0);
      plan_row(POLICY_FIRST, OP_ADD, 100, 1);
      plan_row(POLICY_FIRST, OP_ADD, 50, 2);
      plan_row(POLICY_FIRST, OP_ADD, 300, 3);
      plan_row(POLICY_FIRST, OP_ADD, 50, 4);
      plan_row(POLICY_FIRST, OP_ADD, 1000, 5);
      plan_checked(POLICY_FIRST, OP_ADD, 65535, 6, STATUS_OK, 7, 65535, 8, 132570, 0, 0);
      plan_checked(POLICY_FIRST, OP_ADD, 1, 7, STATUS_FULL, 0, 0, 8, 132570, 0, 0);
      plan_row(POLICY_FIRST, OP_ALLOC, 65535, 0);
      plan_row(POLICY_FIRST, OP_ALLOC, 60, 8'h55);
      plan_row(POLICY_BEST, OP_ALLOC, 40, 8'hAA);
      plan_row(POLICY_BEST, OP_ALLOC, 0, 8'h0F);
      plan_row(POLICY_WORST, OP_ALLOC, 10, 8'hF0);
      plan_row(POLICY_WORST, OP_ALLOC, 65535, 8'h81);
      plan_row(POLICY_WORST, OP_ALLOC, 20, 8'h7E);
      plan_row(POLICY_RESERVED, OP_ALLOC, 400, 8'h33);
      plan_row(POLICY_RESERVED, OP_ALLOC, 0, 8'hCC);
      plan_checked(POLICY_RESERVED, OP_ADD, 65535, 0, STATUS_FULL, 0, 0, 1, 50, 7, 132520);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      rsp_stall_pct = 66;
      foreach (directed_plan[k]) begin
         if (directed_plan[k].policy != policy_now) begin
            wait_drained();
            write_policy(directed_plan[k].policy);
         end
         send_request(directed_plan[k].req, directed_plan[k].typed, directed_plan[k].want);
      end

      phase_policy[0] = POLICY_FIRST;
      phase_policy[1] = POLICY_WORST;
      phase_policy[2] = 2'($urandom_range(0, 3));
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 66 : 0;
         rsp_stall_pct = (phase == 0) ? 66 : (phase == 1) ? 20 : 0;
         wait_drained();
         write_policy(phase_policy[phase]);
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            r.opcode = 1'($urandom_range(0, 1));
            r.amount = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 400))
                                                   : 16'($urandom);
            r.owner_id = 8'($urandom);
            if ($urandom_range(0, 39) == 0) begin
               wait_drained();
            end
            send_request(r, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (2 * (TABLE_DEPTH + 3)) @(posedge clock);
      $display("Sent %0d requests across all four policy codes with varied back-pressure.",
               request_count);
      $display("Checked %0d responses: %0d placed, %0d table full, %0d no fit.",
               response_count, placed_count, full_count, no_fit_count);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("fixed_partition_fit_allocator_core_test: done, clean");
      end else begin
         $display("fixed_partition_fit_allocator_core_test: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/fpfa_pkg.sv
rtl/fpfa_cell.sv
rtl/fixed_partition_fit_allocator_core.sv
verif/fixed_partition_fit_allocator_core_test.sv
